[hw/rtl/pgns_pkg.sv]
// Shared types, constants and offset tables for the periodic grid neighbor sites block.
// Used by pgns_ctrl, pgns_datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package pgns_pkg;

   localparam int unsigned COORD_W = 10;
   localparam int unsigned EXT_W   = 11;
   localparam int unsigned K_W     = 6;
   localparam int unsigned SEEN_N  = 9;

   localparam logic [EXT_W-1:0] MAX_GRID = 11'd1024;
   localparam logic [EXT_W-1:0] MIN_GRID = 11'd4;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;

   typedef enum logic [1:0] {
      OP_CROSS  = 2'd0,
      OP_WINDOW = 2'd1,
      OP_SWAP   = 2'd2,
      OP_UNDEF  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GEN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic           load;
      logic           step;
      logic           flush;
      logic [K_W-1:0] k;
   } cmd_type;

   typedef struct packed {
      logic   in_bad;
      logic   keep;
      logic   pend_valid;
      logic   out_free;
      op_type op;
   } status_type;

   typedef struct packed {
      logic              use_other;
      logic signed [2:0] dr;
      logic signed [2:0] dc;
   } offset_type;

   function automatic logic [K_W-1:0] last_index(op_type op);
      logic [K_W-1:0] r;
      unique case (op)
         OP_CROSS:  r = 6'd12;
         OP_WINDOW: r = 6'd48;
         OP_SWAP:   r = 6'd8;
         default:   r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic offset_type step_offset(op_type op, logic [K_W-1:0] k);
      offset_type o;
      logic [2:0] a;
      logic [K_W-1:0] b;
      o = '0;
      a = '0;
      for (int i = 1; i <= 6; i++) begin
         if (k >= K_W'(7 * i)) begin
            a = a + 3'd1;
         end
      end
      b = k - ({a, 3'b000} - {3'b000, a});
      unique case (op)
         OP_CROSS: begin
            case (k)
               6'd0:  o.dr = -3'sd2;
               6'd1:  o.dr = -3'sd1;
               6'd2:  o.dr = 3'sd0;
               6'd3:  o.dr = 3'sd1;
               6'd4:  o.dr = 3'sd2;
               6'd5:  o.dc = -3'sd2;
               6'd6:  o.dc = -3'sd1;
               6'd7:  o.dc = 3'sd1;
               6'd8:  o.dc = 3'sd2;
               6'd9:  begin o.dr = 3'sd1;  o.dc = 3'sd1;  end
               6'd10: begin o.dr = -3'sd1; o.dc = 3'sd1;  end
               6'd11: begin o.dr = 3'sd1;  o.dc = -3'sd1; end
               default: begin o.dr = -3'sd1; o.dc = -3'sd1; end
            endcase
         end
         OP_WINDOW: begin
            o.dr = $signed(3'(a - 3'd3));
            o.dc = $signed(3'(b[2:0] - 3'd3));
         end
         OP_SWAP: begin
            case (k)
               6'd0: o = '0;
               6'd1: o.dr = -3'sd1;
               6'd2: o.dr = 3'sd1;
               6'd3: o.dc = -3'sd1;
               6'd4: o.dc = 3'sd1;
               6'd5: begin o.use_other = 1'b1; o.dr = -3'sd1; end
               6'd6: begin o.use_other = 1'b1; o.dr = 3'sd1;  end
               6'd7: begin o.use_other = 1'b1; o.dc = -3'sd1; end
               default: begin o.use_other = 1'b1; o.dc = 3'sd1; end
            endcase
         end
         default: o = '0;
      endcase
      return o;
   endfunction

   function automatic logic [COORD_W-1:0] wrap(logic [COORD_W-1:0] v,
                                               logic signed [2:0] d,
                                               logic [EXT_W-1:0] n);
      logic signed [EXT_W:0] s;
      logic signed [EXT_W:0] n_s;
      logic signed [EXT_W:0] r;
      n_s = $signed({1'b0, n});
      s   = $signed({2'b00, v}) + $signed({{(EXT_W-2){d[2]}}, d});
      if (s[EXT_W]) begin
         r = s + n_s;
      end else if (s >= n_s) begin
         r = s - n_s;
      end else begin
         r = s;
      end
      return r[COORD_W-1:0];
   endfunction

endpackage

[hw/rtl/pgns_ctrl.sv]
// Controller state machine: walks the candidate index and sequences load, step and flush.
// Depends on pgns_pkg.
`timescale 1ns / 1ps

module pgns_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pgns_pkg::status_type st,
   output pgns_pkg::cmd_type    cmd
);

   pgns_pkg::state_type           state_ff, state_in;
   logic [pgns_pkg::K_W-1:0]      k_ff, k_in;
   logic                          advance;
   logic                          at_last;

   assign advance = !(st.keep && st.pend_valid && !st.out_free);
   assign at_last = (k_ff == pgns_pkg::last_index(st.op));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pgns_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = st.in_bad ? pgns_pkg::ST_FLUSH : pgns_pkg::ST_GEN;
            end
         end
         pgns_pkg::ST_GEN: begin
            if (advance && at_last) begin
               state_in = pgns_pkg::ST_FLUSH;
            end
         end
         pgns_pkg::ST_FLUSH: begin
            if (st.out_free) begin
               state_in = pgns_pkg::ST_IDLE;
            end
         end
         default: state_in = pgns_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      cmd.k      = k_ff;
      k_in       = k_ff;
      unique case (state_ff)
         pgns_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            k_in       = '0;
         end
         pgns_pkg::ST_GEN: begin
            cmd.step = advance;
            if (advance) begin
               k_in = k_ff + 1'b1;
            end
         end
         pgns_pkg::ST_FLUSH: begin
            cmd.flush = st.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgns_pkg::ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

endmodule

[hw/rtl/pgns_datapath.sv]
// Datapath: extent registers, captured sites, wrapped candidate, duplicate list,
// one-deep pending word and the output register. Depends on pgns_pkg.
`timescale 1ns / 1ps

module pgns_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [1:0]                    csr_index,
   input  logic [pgns_pkg::EXT_W-1:0]    csr_data,
   input  logic [1:0]                    in_op,
   input  logic [pgns_pkg::COORD_W-1:0]  in_row,
   input  logic [pgns_pkg::COORD_W-1:0]  in_col,
   input  logic [pgns_pkg::COORD_W-1:0]  in_oth_row,
   input  logic [pgns_pkg::COORD_W-1:0]  in_oth_col,
   input  pgns_pkg::cmd_type             cmd,
   output pgns_pkg::status_type          st,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [pgns_pkg::COORD_W-1:0]  rsp_row,
   output logic [pgns_pkg::COORD_W-1:0]  rsp_col,
   output logic                          rsp_last,
   output logic                          rsp_bad
);

   localparam int unsigned CW = pgns_pkg::COORD_W;
   localparam int unsigned NS = pgns_pkg::SEEN_N;

   logic [pgns_pkg::EXT_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [pgns_pkg::EXT_W-1:0] csr_eff;
   pgns_pkg::op_type           op_ff, op_in;
   logic [CW-1:0]              row_ff, row_in, col_ff, col_in;
   logic [CW-1:0]              oth_row_ff, oth_row_in, oth_col_ff, oth_col_in;
   logic [CW-1:0]              seen_row_ff [NS], seen_row_in [NS];
   logic [CW-1:0]              seen_col_ff [NS], seen_col_in [NS];
   logic [NS-1:0]              seen_vld_ff, seen_vld_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       pend_bad_ff, pend_bad_in;
   logic [CW-1:0]              pend_row_ff, pend_row_in, pend_col_ff, pend_col_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_bad_ff, rsp_bad_in;
   logic [CW-1:0]              rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   pgns_pkg::offset_type       off;
   logic [CW-1:0]              base_row, base_col, cand_row, cand_col;
   logic [NS-1:0]              hit;
   logic                       in_bad, keep, out_free, move;

   always_comb begin
      csr_eff = csr_data;
      if (csr_data < pgns_pkg::MIN_GRID) begin
         csr_eff = pgns_pkg::MIN_GRID;
      end else if (csr_data > pgns_pkg::MAX_GRID) begin
         csr_eff = pgns_pkg::MAX_GRID;
      end
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid && csr_index == pgns_pkg::REG_ROWS) begin
         rows_in = csr_eff;
      end
      if (csr_valid && csr_index == pgns_pkg::REG_COLS) begin
         cols_in = csr_eff;
      end
   end

   assign in_bad = (pgns_pkg::op_type'(in_op) == pgns_pkg::OP_UNDEF) ||
                   ({1'b0, in_row} >= rows_ff) || ({1'b0, in_col} >= cols_ff) ||
                   ((pgns_pkg::op_type'(in_op) == pgns_pkg::OP_SWAP) &&
                    (({1'b0, in_oth_row} >= rows_ff) || ({1'b0, in_oth_col} >= cols_ff)));

   assign off      = pgns_pkg::step_offset(op_ff, cmd.k);
   assign base_row = off.use_other ? oth_row_ff : row_ff;
   assign base_col = off.use_other ? oth_col_ff : col_ff;
   assign cand_row = pgns_pkg::wrap(base_row, off.dr, rows_ff);
   assign cand_col = pgns_pkg::wrap(base_col, off.dc, cols_ff);

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         hit[i] = seen_vld_ff[i] && (seen_row_ff[i] == cand_row) &&
                  (seen_col_ff[i] == cand_col);
      end
   end

   assign keep     = (op_ff != pgns_pkg::OP_SWAP) || (hit == '0);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign move     = (cmd.step && keep && pend_valid_ff) || cmd.flush;

   assign st.in_bad     = in_bad;
   assign st.keep       = keep;
   assign st.pend_valid = pend_valid_ff;
   assign st.out_free   = out_free;
   assign st.op         = op_ff;

   always_comb begin
      op_in         = op_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      oth_row_in    = oth_row_ff;
      oth_col_in    = oth_col_ff;
      seen_row_in   = seen_row_ff;
      seen_col_in   = seen_col_ff;
      seen_vld_in   = seen_vld_ff;
      pend_valid_in = pend_valid_ff;
      pend_bad_in   = pend_bad_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;

      if (cmd.load) begin
         op_in         = pgns_pkg::op_type'(in_op);
         row_in        = in_row;
         col_in        = in_col;
         oth_row_in    = in_oth_row;
         oth_col_in    = in_oth_col;
         seen_vld_in   = '0;
         pend_valid_in = in_bad;
         pend_bad_in   = in_bad;
         pend_row_in   = '0;
         pend_col_in   = '0;
      end

      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.flush;
         rsp_bad_in   = pend_bad_ff;
         rsp_row_in   = pend_row_ff;
         rsp_col_in   = pend_col_ff;
      end

      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end

      if (cmd.step && keep) begin
         pend_valid_in  = 1'b1;
         pend_bad_in    = 1'b0;
         pend_row_in    = cand_row;
         pend_col_in    = cand_col;
         seen_row_in[0] = cand_row;
         seen_col_in[0] = cand_col;
         seen_vld_in[0] = 1'b1;
         for (int i = 1; i < NS; i++) begin
            seen_row_in[i] = seen_row_ff[i-1];
            seen_col_in[i] = seen_col_ff[i-1];
            seen_vld_in[i] = seen_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= pgns_pkg::MAX_GRID;
         cols_ff       <= pgns_pkg::MAX_GRID;
         seen_vld_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         seen_vld_ff   <= seen_vld_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      oth_row_ff  <= oth_row_in;
      oth_col_ff  <= oth_col_in;
      seen_row_ff <= seen_row_in;
      seen_col_ff <= seen_col_in;
      pend_bad_ff <= pend_bad_in;
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_bad    = rsp_bad_ff;

endmodule

[hw/rtl/periodic_grid_neighbor_sites.sv]
// Top level of the periodic grid neighbor sites generator.
// Instantiates pgns_ctrl and pgns_datapath; depends on pgns_pkg.
//
//   channel   dir   handshake              payload
//   req_      in    req_tvalid/req_tready  tdata: sites, tuser: operation
//   rsp_      out   rsp_tvalid/rsp_tready  tdata: wrapped site, tlast, tuser: bad
//   csr_      in    csr_valid/csr_ready    csr_index, csr_data
//
// One candidate site is evaluated per cycle by the step counter in pgns_ctrl.
// An item walks N candidates: N = 13 (cross), 49 (window), 9 (swap); an error item gives one word.
// A one-deep pending word ahead of the output register marks the final word of a run.
// Output stalls hold the step counter; req_tready is high only between items.
// Synchronous reset sets both extents to 1024 and empties all pipeline words.
`timescale 1ns / 1ps

module periodic_grid_neighbor_sites (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // site_row, site_col, other_row, other_col
   input  logic [1:0]  req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_row, out_col, zero pad
   output logic        rsp_tlast,
   output logic        rsp_tuser,  // bad_site
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   pgns_pkg::cmd_type                cmd;
   pgns_pkg::status_type             st;
   logic [pgns_pkg::COORD_W-1:0]     rsp_row, rsp_col;

   assign csr_ready = 1'b1;

   pgns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   pgns_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .in_op      (req_tuser),
      .in_row     (req_tdata[9:0]),
      .in_col     (req_tdata[19:10]),
      .in_oth_row (req_tdata[29:20]),
      .in_oth_col (req_tdata[39:30]),
      .cmd        (cmd),
      .st         (st),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_last   (rsp_tlast),
      .rsp_bad    (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, rsp_col, rsp_row};

endmodule

[hw/rtl/pgns_chk.sv]
// Port-level checker for periodic_grid_neighbor_sites, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module pgns_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 24'd0)
      else $error("bad-site word must be a lone zero word");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken again before the run finished");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:20] == 4'd0)
      else $error("rsp pad bits not zero");

endmodule

bind periodic_grid_neighbor_sites pgns_chk u_pgns_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[bench/periodic_grid_neighbor_sites_tb.sv]
// Self-checking bench for periodic_grid_neighbor_sites: a directed table, then random requests
// over several grid extents; each result word is checked against a predictor or a planned error word.
// Depends on pgns_pkg and the RTL of the block.
`timescale 1ns / 1ps

module periodic_grid_neighbor_sites_tb;

   localparam int unsigned CW = pgns_pkg::COORD_W;
   localparam int unsigned EW = pgns_pkg::EXT_W;

   typedef struct {
      logic [CW-1:0] row;
      logic [CW-1:0] col;
      logic          last;
      logic          bad;
   } site_word_type;

   typedef struct {
      bit                 is_cfg;
      logic [1:0]         idx;
      logic [EW-1:0]      val;
      pgns_pkg::op_type   op;
      logic [CW-1:0]      sr;
      logic [CW-1:0]      sc;
      logic [CW-1:0]      orow;
      logic [CW-1:0]      ocol;
      bit                 typed;
      site_word_type      want;
   } plan_row_type;

   typedef enum logic [1:0] {
      MODE_SLOW_RSP,
      MODE_SLOW_REQ,
      MODE_NONE
   } idle_mode_type;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int RAND_BLOCKS     = 9;
   localparam int BLOCK_ITEMS     = 36;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 60;
   localparam int MAX_REPORTS     = 10;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [39:0]        req_tdata  = '0;
   logic [1:0]         req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [23:0]        rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index  = '0;
   logic [EW-1:0]      csr_data   = '0;

   logic [EW-1:0]      grid_rows_q = pgns_pkg::MAX_GRID;
   logic [EW-1:0]      grid_cols_q = pgns_pkg::MAX_GRID;
   idle_mode_type      idle_mode   = MODE_SLOW_RSP;

   site_word_type      expected_sites[$];
   plan_row_type       plan[$];

   int mismatches    = 0;
   int unexpected    = 0;
   int sites_checked = 0;
   int bad_words     = 0;
   int requests      = 0;
   int cfg_writes    = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   periodic_grid_neighbor_sites uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int eff_extent(logic [EW-1:0] v);
      if (v < pgns_pkg::MIN_GRID) return int'(pgns_pkg::MIN_GRID);
      if (v > pgns_pkg::MAX_GRID) return int'(pgns_pkg::MAX_GRID);
      return int'(v);
   endfunction

   function automatic logic [CW-1:0] wrap_coord(int v, int d, int n);
      int s;
      s = v + d;
      if (s < 0) s = s + n;
      else if (s >= n) s = s - n;
      return CW'(s);
   endfunction

   // Expand one request into its run of sites and queue them.
   function automatic void predict_sites(pgns_pkg::op_type op, logic [CW-1:0] sr,
                                         logic [CW-1:0] sc, logic [CW-1:0] orow,
                                         logic [CW-1:0] ocol);
      int            nr, nc, i, j, x, y;
      int            cand_r[9];
      int            cand_c[9];
      bit            seen;
      site_word_type run[$];
      site_word_type w;
      nr = eff_extent(grid_rows_q);
      nc = eff_extent(grid_cols_q);
      i = int'(sr);
      j = int'(sc);
      x = int'(orow);
      y = int'(ocol);
      w.last = 1'b0;
      w.bad  = 1'b0;
      if (op == pgns_pkg::OP_UNDEF || i >= nr || j >= nc ||
          (op == pgns_pkg::OP_SWAP && (x >= nr || y >= nc))) begin
         w.row  = '0;
         w.col  = '0;
         w.last = 1'b1;
         w.bad  = 1'b1;
         expected_sites.push_back(w);
         return;
      end
      case (op)
         pgns_pkg::OP_CROSS: begin
            for (int d = -2; d <= 2; d++) begin
               w.row = wrap_coord(i, d, nr);
               w.col = CW'(j);
               run.push_back(w);
            end
            for (int d = -2; d <= 2; d++) begin
               if (d != 0) begin
                  w.row = CW'(i);
                  w.col = wrap_coord(j, d, nc);
                  run.push_back(w);
               end
            end
            for (int k = 0; k < 4; k++) begin
               w.row = wrap_coord(i, (k % 2 == 0) ? 1 : -1, nr);
               w.col = wrap_coord(j, (k < 2) ? 1 : -1, nc);
               run.push_back(w);
            end
         end
         pgns_pkg::OP_WINDOW: begin
            for (int a = -3; a <= 3; a++) begin
               for (int b = -3; b <= 3; b++) begin
                  w.row = wrap_coord(i, a, nr);
                  w.col = wrap_coord(j, b, nc);
                  run.push_back(w);
               end
            end
         end
         default: begin
            cand_r[0] = i;                          cand_c[0] = j;
            cand_r[1] = int'(wrap_coord(i, -1, nr)); cand_c[1] = j;
            cand_r[2] = int'(wrap_coord(i, 1, nr));  cand_c[2] = j;
            cand_r[3] = i;                          cand_c[3] = int'(wrap_coord(j, -1, nc));
            cand_r[4] = i;                          cand_c[4] = int'(wrap_coord(j, 1, nc));
            cand_r[5] = int'(wrap_coord(x, -1, nr)); cand_c[5] = y;
            cand_r[6] = int'(wrap_coord(x, 1, nr));  cand_c[6] = y;
            cand_r[7] = x;                          cand_c[7] = int'(wrap_coord(y, -1, nc));
            cand_r[8] = x;                          cand_c[8] = int'(wrap_coord(y, 1, nc));
            // drop a site already in the run
            for (int k = 0; k < 9; k++) begin
               seen = 1'b0;
               foreach (run[m]) begin
                  if (int'(run[m].row) == cand_r[k] && int'(run[m].col) == cand_c[k])
                     seen = 1'b1;
               end
               if (!seen) begin
                  w.row = CW'(cand_r[k]);
                  w.col = CW'(cand_c[k]);
                  run.push_back(w);
               end
            end
         end
      endcase
      run[run.size()-1].last = 1'b1;
      foreach (run[m]) expected_sites.push_back(run[m]);
   endfunction

   function automatic void plan_cfg(logic [1:0] idx, logic [EW-1:0] val);
      plan_row_type r;
      r.is_cfg = 1'b1;
      r.idx    = idx;
      r.val    = val;
      r.op     = pgns_pkg::OP_CROSS;
      r.typed  = 1'b0;
      plan.push_back(r);
   endfunction

   function automatic void plan_item(pgns_pkg::op_type op, int sr, int sc, int orow, int ocol);
      plan_row_type r;
      r.is_cfg = 1'b0;
      r.idx    = pgns_pkg::REG_ROWS;
      r.val    = '0;
      r.op     = op;
      r.sr     = CW'(sr);
      r.sc     = CW'(sc);
      r.orow   = CW'(orow);
      r.ocol   = CW'(ocol);
      r.typed  = 1'b0;
      plan.push_back(r);
   endfunction

   // An out-of-grid site or an undefined operation gives one error word at the origin.
   function automatic void plan_bad(pgns_pkg::op_type op, int sr, int sc, int orow, int ocol);
      plan_item(op, sr, sc, orow, ocol);
      plan[plan.size()-1].typed     = 1'b1;
      plan[plan.size()-1].want.row  = '0;
      plan[plan.size()-1].want.col  = '0;
      plan[plan.size()-1].want.last = 1'b1;
      plan[plan.size()-1].want.bad  = 1'b1;
   endfunction

   function automatic logic [EW-1:0] pick_extent();
      case ($urandom_range(0, 5))
         0:       return pgns_pkg::MIN_GRID;
         1:       return pgns_pkg::MAX_GRID;
         2:       return EW'($urandom_range(0, 3));
         3:       return EW'($urandom_range(1025, 2047));
         4:       return EW'($urandom_range(4, 16));
         default: return EW'($urandom_range(4, 1024));
      endcase
   endfunction

   function automatic logic [CW-1:0] pick_coord(int n);
      int r, k;
      r = int'($urandom_range(0, 99));
      k = int'($urandom_range(0, 2));
      if (r < 3 && n < 1024) return CW'($urandom_range(n, 1023));
      if (r < 18) return CW'(k);
      if (r < 33) return CW'(n - 1 - k);
      return CW'($urandom_range(0, n - 1));
   endfunction

   task automatic send_request(pgns_pkg::op_type op, logic [CW-1:0] sr, logic [CW-1:0] sc,
                               logic [CW-1:0] orow, logic [CW-1:0] ocol);
      while (int'($urandom_range(0, 99)) <
             ((idle_mode == MODE_SLOW_RSP) ? 7 : (idle_mode == MODE_SLOW_REQ) ? 86 : 0)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ocol, orow, sc, sr};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      requests++;
   endtask

   // Drain the block, then write one register.
   task automatic write_reg(logic [1:0] idx, logic [EW-1:0] val);
      req_tvalid <= 1'b0;
      while (expected_sites.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == pgns_pkg::REG_ROWS) grid_rows_q = val;
      else if (idx == pgns_pkg::REG_COLS) grid_cols_q = val;
      cfg_writes++;
   endtask

   // hold off once for a long stretch so the block backs up into its input
   always @(posedge clock) begin : hold_off
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && idle_mode == MODE_NONE) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      site_word_type got;
      site_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.row  = rsp_tdata[CW-1:0];
            got.col  = rsp_tdata[2*CW-1:CW];
            got.last = rsp_tlast;
            got.bad  = rsp_tuser;
            if (expected_sites.size() == 0) begin
               unexpected++;
               if (mismatches + unexpected <= MAX_REPORTS)
                  $display("unexpected word: row %0d col %0d last %0b bad %0b",
                           got.row, got.col, got.last, got.bad);
            end else begin
               want = expected_sites.pop_front();
               sites_checked++;
               if (want.bad) bad_words++;
               if (got.row !== want.row || got.col !== want.col ||
                   got.last !== want.last || got.bad !== want.bad) begin
                  mismatches++;
                  if (mismatches + unexpected <= MAX_REPORTS)
                     $display("mismatch at %0t: exp %0d,%0d l%0b b%0b got %0d,%0d l%0b b%0b",
                              $realtime, want.row, want.col, want.last, want.bad,
                              got.row, got.col, got.last, got.bad);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= int'($urandom_range(0, 99)) >=
                          ((idle_mode == MODE_SLOW_RSP) ? 86 :
                           (idle_mode == MODE_SLOW_REQ) ? 7 : 0);
         end
      end
   end

   initial begin : stimulus
      pgns_pkg::op_type   op;
      logic [CW-1:0]      sr, sc, orow, ocol;
      int                 nr, nc, directed;

      // reset extents 1024 x 1024
      plan_item(pgns_pkg::OP_CROSS,     0,    0,    0,    0);
      plan_item(pgns_pkg::OP_CROSS,  1023, 1023, 1023, 1023);
      plan_item(pgns_pkg::OP_WINDOW,    0,    0, 1023, 1023);
      plan_item(pgns_pkg::OP_WINDOW, 1023, 1023,    0,    0);
      plan_item(pgns_pkg::OP_SWAP,      0,    0,    0,    1);
      plan_item(pgns_pkg::OP_SWAP,      5,    5,    5,    5);
      plan_item(pgns_pkg::OP_SWAP,   1023, 1023,    0,    0);
      plan_bad (pgns_pkg::OP_UNDEF,     0,    0,    0,    0);
      plan_bad (pgns_pkg::OP_UNDEF,  1023, 1023, 1023, 1023);
      // smallest grid
      plan_cfg (pgns_pkg::REG_ROWS, pgns_pkg::MIN_GRID);
      plan_cfg (pgns_pkg::REG_COLS, pgns_pkg::MIN_GRID);
      plan_item(pgns_pkg::OP_CROSS,     0,    0,    0,    0);
      plan_item(pgns_pkg::OP_CROSS,     3,    3,    0,    0);
      plan_item(pgns_pkg::OP_WINDOW,    1,    2,    0,    0);
      plan_item(pgns_pkg::OP_SWAP,      0,    0,    3,    3);
      plan_bad (pgns_pkg::OP_CROSS,     4,    0,    0,    0);
      plan_bad (pgns_pkg::OP_WINDOW,    0,    4,    0,    0);
      plan_bad (pgns_pkg::OP_SWAP,      1,    1,    4,    1);
      plan_bad (pgns_pkg::OP_SWAP,      1,    1,    1, 1023);
      plan_item(pgns_pkg::OP_CROSS,     2,    2, 1023, 1023);
      // extents outside the legal range clamp
      plan_cfg (pgns_pkg::REG_ROWS, 11'd0);
      plan_cfg (pgns_pkg::REG_COLS, 11'd2047);
      plan_item(pgns_pkg::OP_WINDOW,    3, 1023,    0,    0);
      plan_item(pgns_pkg::OP_SWAP,      3,    0,    0, 1023);
      plan_bad (pgns_pkg::OP_CROSS,  1023,    5,    0,    0);
      plan_cfg (pgns_pkg::REG_ROWS, 11'd2047);
      plan_cfg (pgns_pkg::REG_COLS, 11'd0);
      plan_item(pgns_pkg::OP_CROSS,  1023,    3,    0,    0);
      plan_bad (pgns_pkg::OP_WINDOW,    0,    4,    0,    0);
      plan_cfg (REG_UNUSED, 11'd2047);
      plan_item(pgns_pkg::OP_SWAP,   1000,    2, 1001,    3);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[p]) begin
         if (plan[p].is_cfg) begin
            write_reg(plan[p].idx, plan[p].val);
         end else begin
            send_request(plan[p].op, plan[p].sr, plan[p].sc, plan[p].orow, plan[p].ocol);
            if (plan[p].typed) expected_sites.push_back(plan[p].want);
            else predict_sites(plan[p].op, plan[p].sr, plan[p].sc, plan[p].orow, plan[p].ocol);
         end
      end
      directed = requests;

      for (int b = 0; b < RAND_BLOCKS; b++) begin
         write_reg(pgns_pkg::REG_ROWS, pick_extent());
         write_reg(pgns_pkg::REG_COLS, pick_extent());
         idle_mode <= idle_mode_type'(b / 3);
         nr = eff_extent(grid_rows_q);
         nc = eff_extent(grid_cols_q);
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 5) op = pgns_pkg::OP_UNDEF;
            else op = pgns_pkg::op_type'($urandom_range(0, 2));
            sr = pick_coord(nr);
            sc = pick_coord(nc);
            if (op != pgns_pkg::OP_SWAP) begin
               orow = CW'($urandom);
               ocol = CW'($urandom);
            end else if ($urandom_range(0, 1) == 1) begin
               // partner close by, so the two neighborhoods can overlap
               orow = wrap_coord(int'(sr), int'($urandom_range(0, 4)) - 2, nr);
               ocol = wrap_coord(int'(sc), int'($urandom_range(0, 4)) - 2, nc);
            end else begin
               orow = pick_coord(nr);
               ocol = pick_coord(nc);
            end
            send_request(op, sr, sc, orow, ocol);
            predict_sites(op, sr, sc, orow, ocol);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_sites.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d directed) over %0d register writes",
               requests, directed, cfg_writes);
      $display("checked %0d site words, %0d of them error words; %0d mismatches, %0d unexpected",
               sites_checked, bad_words, mismatches, unexpected);
      if (mismatches == 0 && unexpected == 0 && expected_sites.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(10_000_000);
      $display("FAIL");
      $finish;
   end

endmodule
